// File: rtl/tll_pkg.sv
package tll_pkg;

    localparam int CNT_W   = 16;
    localparam int FIELD_W = 16;
    localparam int TYPE_W  = 4;
    localparam int KM_W    = 4;

    localparam int QD      = 8;
    localparam int QA_W    = $clog2(QD);
    localparam int QC_W    = $clog2(QD + 1);

    localparam logic [TYPE_W-1:0] TT_END   = 4'd0;
    localparam logic [TYPE_W-1:0] TT_NUM   = 4'd1;
    localparam logic [TYPE_W-1:0] TT_STR   = 4'd2;
    localparam logic [TYPE_W-1:0] TT_ID    = 4'd3;
    localparam logic [TYPE_W-1:0] TT_PRINT = 4'd4;
    localparam logic [TYPE_W-1:0] TT_ADD   = 4'd5;
    localparam logic [TYPE_W-1:0] TT_SUB   = 4'd6;
    localparam logic [TYPE_W-1:0] TT_MUL   = 4'd7;
    localparam logic [TYPE_W-1:0] TT_DIV   = 4'd8;
    localparam logic [TYPE_W-1:0] TT_LPAR  = 4'd9;
    localparam logic [TYPE_W-1:0] TT_RPAR  = 4'd10;
    localparam logic [TYPE_W-1:0] TT_SEMI  = 4'd11;

    localparam int              KW_LEN  = 5;
    localparam logic [KM_W-1:0] KW_MISS = 4'd8;

    typedef struct packed {
        logic [TYPE_W-1:0]  token_type;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] token_len;
        logic [FIELD_W-1:0] line_no;
        logic [FIELD_W-1:0] column_no;
        logic               last;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok0;
        t_tok       tok1;
    } t_push;

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "p";
            3'd1:    c = "r";
            3'd2:    c = "i";
            3'd3:    c = "n";
            3'd4:    c = "t";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : CNT_W'(v + 1'b1);
    endfunction

endpackage

// File: rtl/tll_scan.sv
module tll_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_ch,
    output tll_pkg::t_push o_push
);
    import tll_pkg::*;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_NUM   = 2'd1;
    localparam logic [1:0] MODE_STR   = 2'd2;
    localparam logic [1:0] MODE_IDENT = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_QUOTE = 8'd34;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [1:0]       r_mode,   n_mode;
    logic [CNT_W-1:0] r_pos,    n_pos;
    logic [CNT_W-1:0] r_line,   n_line;
    logic [CNT_W-1:0] r_col,    n_col;
    logic [CNT_W-1:0] r_pstart, n_pstart;
    logic [CNT_W-1:0] r_pline,  n_pline;
    logic [CNT_W-1:0] r_pcol,   n_pcol;
    logic [CNT_W-1:0] r_plen,   n_plen;
    logic [KM_W-1:0]  r_km,     n_km;

    logic is_dig, is_alp, is_sp, cont, kw_hit;
    logic flush_v, idle_en, idle_v;
    t_tok flush_tok, idle_tok;
    t_push push;

    always_comb begin
        is_dig = (i_ch >= "0") && (i_ch <= "9");
        is_alp = ((i_ch >= "a") && (i_ch <= "z")) || ((i_ch >= "A") && (i_ch <= "Z"));
        is_sp  = (i_ch == " ") || ((i_ch >= 8'd9) && (i_ch <= 8'd13));
        kw_hit = !r_km[KM_W-1] && (r_plen < CNT_W'(KW_LEN))
                 && (i_ch == kw_char(r_plen[2:0]));
        cont   = (r_mode == MODE_NUM) ? is_dig : (is_dig || is_alp);

        n_mode   = r_mode;
        n_pos    = r_pos;
        n_line   = r_line;
        n_col    = r_col;
        n_pstart = r_pstart;
        n_pline  = r_pline;
        n_pcol   = r_pcol;
        n_plen   = r_plen;
        n_km     = r_km;

        flush_v   = 1'b0;
        idle_en   = 1'b0;
        idle_v    = 1'b0;
        flush_tok = '0;
        idle_tok  = '0;

        flush_tok.start_offset = FIELD_W'(r_pstart);
        flush_tok.token_len    = FIELD_W'(r_plen);
        flush_tok.line_no      = FIELD_W'(r_pline);
        flush_tok.column_no    = FIELD_W'(r_pcol);

        unique case (r_mode) inside
            MODE_NUM, MODE_IDENT: begin
                if (cont) begin
                    if (r_mode == MODE_IDENT) begin
                        n_km = kw_hit ? KM_W'(r_km + 1'b1) : (r_km | KW_MISS);
                    end
                    n_plen = sat_inc(r_plen);
                    n_pos  = sat_inc(r_pos);
                    n_col  = sat_inc(r_col);
                end else begin
                    flush_v = 1'b1;
                    if (r_mode == MODE_NUM) begin
                        flush_tok.token_type = TT_NUM;
                    end else if (!r_km[KM_W-1] && (r_km[2:0] == 3'(KW_LEN))
                                 && (r_plen == CNT_W'(KW_LEN))) begin
                        flush_tok.token_type = TT_PRINT;
                    end else begin
                        flush_tok.token_type = TT_ID;
                    end
                    n_mode  = MODE_IDLE;
                    idle_en = 1'b1;
                end
            end
            MODE_STR: begin
                flush_tok.token_type = TT_STR;
                if (i_ch == CH_NUL) begin
                    flush_v = 1'b1;
                    n_mode  = MODE_IDLE;
                    idle_en = 1'b1;
                end else if (i_ch == CH_QUOTE) begin
                    flush_v = 1'b1;
                    n_pos   = sat_inc(r_pos);
                    n_col   = sat_inc(r_col);
                    n_mode  = MODE_IDLE;
                end else begin
                    n_plen = sat_inc(r_plen);
                    n_pos  = sat_inc(r_pos);
                    n_col  = sat_inc(r_col);
                end
            end
            default: begin
                idle_en = 1'b1;
            end
        endcase

        if (idle_en) begin
            if (i_ch == CH_NUL) begin
                idle_v   = 1'b1;
                idle_tok = '0;
                n_mode   = MODE_IDLE;
                n_pos    = '0;
                n_line   = CNT_ONE;
                n_col    = CNT_ONE;
                n_pstart = '0;
                n_pline  = '0;
                n_pcol   = '0;
                n_plen   = '0;
                n_km     = '0;
            end else if (is_sp) begin
                if (i_ch == CH_NL) begin
                    n_line = sat_inc(r_line);
                    n_col  = CNT_ONE;
                end else begin
                    n_col = sat_inc(r_col);
                end
                n_pos = sat_inc(r_pos);
            end else if (i_ch == CH_QUOTE) begin
                n_pline  = r_line;
                n_pcol   = r_col;
                n_pos    = sat_inc(r_pos);
                n_col    = sat_inc(r_col);
                n_pstart = sat_inc(r_pos);
                n_plen   = '0;
                n_mode   = MODE_STR;
            end else if (is_dig || is_alp) begin
                n_pstart = r_pos;
                n_pline  = r_line;
                n_pcol   = r_col;
                n_plen   = CNT_ONE;
                n_pos    = sat_inc(r_pos);
                n_col    = sat_inc(r_col);
                if (is_dig) begin
                    n_mode = MODE_NUM;
                end else begin
                    n_km   = (i_ch == kw_char(3'd0)) ? KM_W'(1) : KW_MISS;
                    n_mode = MODE_IDENT;
                end
            end else begin
                idle_v                = 1'b1;
                idle_tok.start_offset = FIELD_W'(r_pos);
                idle_tok.token_len    = FIELD_W'(1);
                idle_tok.line_no      = FIELD_W'(r_line);
                idle_tok.column_no    = FIELD_W'(r_col);
                unique case (i_ch)
                    "+":     idle_tok.token_type = TT_ADD;
                    "-":     idle_tok.token_type = TT_SUB;
                    "*":     idle_tok.token_type = TT_MUL;
                    "/":     idle_tok.token_type = TT_DIV;
                    "(":     idle_tok.token_type = TT_LPAR;
                    ")":     idle_tok.token_type = TT_RPAR;
                    ";":     idle_tok.token_type = TT_SEMI;
                    default: idle_tok.token_type = TT_END;
                endcase
                n_pos = sat_inc(r_pos);
                n_col = sat_inc(r_col);
            end
        end

        push = '0;
        if (flush_v) begin
            push.tok0 = flush_tok;
            if (idle_v) begin
                push.tok1      = idle_tok;
                push.tok1.last = 1'b1;
                push.cnt       = 2'd2;
            end else begin
                push.tok0.last = 1'b1;
                push.cnt       = 2'd1;
            end
        end else if (idle_v) begin
            push.tok0      = idle_tok;
            push.tok0.last = 1'b1;
            push.cnt       = 2'd1;
        end
        if (!i_valid) begin
            push.cnt = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_line   <= CNT_ONE;
            r_col    <= CNT_ONE;
            r_pstart <= '0;
            r_pline  <= '0;
            r_pcol   <= '0;
            r_plen   <= '0;
            r_km     <= '0;
        end else if (i_valid) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_col    <= n_col;
            r_pstart <= n_pstart;
            r_pline  <= n_pline;
            r_pcol   <= n_pcol;
            r_plen   <= n_plen;
            r_km     <= n_km;
        end
    end

endmodule

// File: rtl/tll_outq.sv
module tll_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tll_pkg::t_push       i_push,
    input  logic                 i_pop,
    output tll_pkg::t_tok        o_head,
    output logic [tll_pkg::QC_W-1:0] o_count
);
    import tll_pkg::*;

    t_tok            r_mem [QD];
    logic [QA_W-1:0] r_wr, n_wr;
    logic [QA_W-1:0] r_rd, n_rd;
    logic [QC_W-1:0] r_cnt, n_cnt;
    logic [QA_W-1:0] wr_next;

    always_comb begin
        wr_next = QA_W'(r_wr + 1'b1);
        n_wr    = QA_W'(r_wr + QA_W'(i_push.cnt));
        n_rd    = i_pop ? QA_W'(r_rd + 1'b1) : r_rd;
        n_cnt   = QC_W'(r_cnt + QC_W'(i_push.cnt) - QC_W'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

// File: rtl/token_lexer_line_col_top.sv
// Streaming lexer: one source byte per word on the ch channel, a zero byte ends the source
// and returns the block to its reset state after the end token. A byte is registered, scanned
// in the next cycle and its tokens (none, one or two) land in an 8-entry result queue, so a
// token reaches the outputs through the input register and the queue memory. Bytes are taken
// one per cycle while the queue has room; a byte can give two tokens but the queue drains one
// per cycle with i_tok_ready high, so ready drops above four tokens with a byte staged, else six.
module token_lexer_line_col_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_ch,
    input  logic        i_ch_valid,
    output logic        o_ch_ready,
    output logic [3:0]  o_token_type,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_len,
    output logic [15:0] o_line_no,
    output logic [15:0] o_column_no,
    output logic        o_last,
    output logic        o_tok_valid,
    input  logic        i_tok_ready
);
    import tll_pkg::*;

    logic            r_in_v;
    logic [7:0]      r_ch;
    t_push           push;
    t_tok            head;
    logic [QC_W-1:0] q_count;
    logic [QC_W:0]   q_need;
    logic            ch_acc;
    logic            tok_pop;

    assign q_need     = (QC_W + 1)'(q_count) + (r_in_v ? (QC_W + 1)'(2) : '0);
    assign o_ch_ready = (q_need <= (QC_W + 1)'(QD - 2));
    assign ch_acc     = i_ch_valid && o_ch_ready;
    assign o_tok_valid = (q_count != '0);
    assign tok_pop    = o_tok_valid && i_tok_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= ch_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ch_acc) begin
            r_ch <= i_ch;
        end
    end

    tll_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_ch    (r_ch),
        .o_push  (push)
    );

    tll_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (tok_pop),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_token_type   = head.token_type;
    assign o_start_offset = head.start_offset;
    assign o_token_len    = head.token_len;
    assign o_line_no      = head.line_no;
    assign o_column_no    = head.column_no;
    assign o_last         = head.last;

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QC_W'(QD))
        else $error("result queue overflow");

    a_in_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ch_acc |=> r_in_v)
        else $error("accepted byte not staged");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt == 2'd2) |-> (!push.tok0.last && push.tok1.last))
        else $error("last flag wrong on token pair");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt == 2'd1) |-> push.tok0.last)
        else $error("last flag missing on single token");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_v |-> (push.cnt == 2'd0))
        else $error("token pushed without a byte");
`endif

endmodule
